/* src/script_source_tokenizer_defines.svh */
// Assertion helpers shared by the tokenizer modules.
`ifndef SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH
`define SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

/* src/stl_pkg.sv */
`default_nettype none
package stl_pkg;

    localparam int LINE_BITS = 16;
    localparam int MAX_RES = 4;

    localparam logic [3:0] CLS_IDENT    = 4'd0;
    localparam logic [3:0] CLS_NUMBER   = 4'd1;
    localparam logic [3:0] CLS_STRING   = 4'd2;
    localparam logic [3:0] CLS_CHAR     = 4'd3;
    localparam logic [3:0] CLS_OPERATOR = 4'd4;
    localparam logic [3:0] CLS_PUNCT    = 4'd5;
    localparam logic [3:0] CLS_AT_NAME  = 4'd6;
    localparam logic [3:0] CLS_EOF      = 4'd7;
    localparam logic [3:0] CLS_ERROR    = 4'd8;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_NAME    = 3'd1;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd4;
    localparam logic [2:0] ERR_OPEN_BLOCK = 3'd5;

    typedef enum logic [3:0] {
        M_IDLE, M_HASH, M_LINECOM, M_BLOCK, M_BLOCKBAR, M_IDENT, M_NUM,
        M_NUMEXPSTART, M_NUMEXP, M_DOT, M_AT, M_STR, M_STRESC, M_CHR,
        M_CHRESC, M_OP
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [7:0]           held0;
        logic [7:0]           held1;
        logic [1:0]           held_count;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] block_line;
        logic                 stopped;
        logic [7:0]           pend_ch;
        logic                 pend_ok;
        logic                 pend_first;
    } lex_state_t;

    typedef struct packed {
        logic [3:0]           cls;
        logic [7:0]           ch;
        logic                 ok;
        logic                 first;
        logic                 fin;
        logic [LINE_BITS-1:0] line;
        logic [2:0]           err;
    } res_t;

    typedef res_t [MAX_RES-1:0] res_vec_t;

    typedef struct packed {
        res_vec_t   res;
        logic [2:0] cnt;
    } batch_t;

    function automatic lex_state_t reset_state();
        lex_state_t st;
        st = '0;
        st.mode = M_IDLE;
        st.line = LINE_BITS'(1);
        st.block_line = LINE_BITS'(1);
        return st;
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_num_char(c);
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return c inside {"=", "!", "<", ">", "&", "|", "+", "-", "*", "/", "%", "^", ":"};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {"(", ")", "{", "}", "[", "]", ",", ";", "?"};
    endfunction

    function automatic logic op_pair(input logic [7:0] a, input logic [7:0] c);
        logic eq_ok;
        logic dbl_ok;
        eq_ok = a inside {"=", "!", "<", ">", "+", "-", "*", "/", "%", "&", "|", "^"};
        dbl_ok = a inside {"&", "|", "+", "-", "<", ">", ":"};
        return (c == "=" && eq_ok) || (c == a && dbl_ok) || (a == "-" && c == ">");
    endfunction

    function automatic res_t mk(input logic [3:0] cls, input logic [7:0] ch,
                                input logic ok, input logic first, input logic fin,
                                input logic [LINE_BITS-1:0] ln, input logic [2:0] err);
        res_t r;
        r.cls = cls;
        r.ch = ok ? ch : 8'h00;
        r.ok = ok;
        r.first = first;
        r.fin = fin;
        r.line = ln;
        r.err = err;
        return r;
    endfunction

    function automatic void push(inout res_vec_t v, inout logic [2:0] n, input res_t r);
        if (n < 3'(MAX_RES))
        begin
            v[n[1:0]] = r;
            n = n + 3'd1;
        end
    endfunction

    function automatic void line_step(inout lex_state_t st);
        if (st.line != '1)
        begin
            st.line = st.line + 1'b1;
        end
    endfunction

    function automatic void go_idle(inout lex_state_t st);
        st.mode = M_IDLE;
        st.held_count = 2'd0;
    endfunction

    function automatic void fail(inout lex_state_t st, inout res_vec_t v, inout logic [2:0] n,
                                 input logic [2:0] code, input logic [LINE_BITS-1:0] ln);
        push(v, n, mk(CLS_ERROR, 8'h00, 1'b0, 1'b1, 1'b1, ln, code));
        st.stopped = 1'b1;
    endfunction

    function automatic void eof_out(inout lex_state_t st, inout res_vec_t v,
                                    inout logic [2:0] n);
        push(v, n, mk(CLS_EOF, 8'h00, 1'b0, 1'b1, 1'b1, st.line, ERR_NONE));
        st.stopped = 1'b1;
    endfunction

    function automatic void tok_start(inout lex_state_t st, input logic [7:0] c);
        st.pend_ch = c;
        st.pend_ok = 1'b1;
        st.pend_first = 1'b1;
    endfunction

    function automatic void tok_add(inout lex_state_t st, inout res_vec_t v, inout logic [2:0] n,
                                    input logic [3:0] cls, input logic [7:0] c);
        if (st.pend_ok)
        begin
            push(v, n, mk(cls, st.pend_ch, 1'b1, st.pend_first, 1'b0, st.line, ERR_NONE));
            st.pend_first = 1'b0;
        end
        st.pend_ch = c;
        st.pend_ok = 1'b1;
    endfunction

    function automatic void tok_finish(inout lex_state_t st, inout res_vec_t v,
                                       inout logic [2:0] n, input logic [3:0] cls);
        if (st.pend_ok)
        begin
            push(v, n, mk(cls, st.pend_ch, 1'b1, st.pend_first, 1'b1, st.line, ERR_NONE));
        end
        else
        begin
            push(v, n, mk(cls, 8'h00, 1'b0, 1'b1, 1'b1, st.line, ERR_NONE));
        end
        st.pend_ok = 1'b0;
        st.pend_first = 1'b0;
    endfunction

    function automatic void single(inout res_vec_t v, inout logic [2:0] n, input logic [3:0] cls,
                                   input logic [7:0] c, input logic [LINE_BITS-1:0] ln);
        push(v, n, mk(cls, c, 1'b1, 1'b1, 1'b1, ln, ERR_NONE));
    endfunction

    function automatic void idle_f(inout lex_state_t st, inout res_vec_t v,
                                   inout logic [2:0] n, input logic [7:0] c);
        if (c == 8'h0A)
        begin
            line_step(st);
        end
        else if (c == " " || c == 8'h09 || c == 8'h0D)
        begin
            st.mode = M_IDLE;
        end
        else if (c == "#")
        begin
            st.mode = M_HASH;
        end
        else if (c == "@")
        begin
            tok_start(st, c);
            st.mode = M_AT;
        end
        else if (c == "\"")
        begin
            st.pend_ok = 1'b0;
            st.pend_first = 1'b1;
            st.mode = M_STR;
        end
        else if (c == "'")
        begin
            st.held_count = 2'd0;
            st.mode = M_CHR;
        end
        else if (is_num_char(c))
        begin
            tok_start(st, c);
            st.mode = M_NUM;
        end
        else if (c == ".")
        begin
            st.mode = M_DOT;
        end
        else if (is_alpha(c))
        begin
            tok_start(st, c);
            st.mode = M_IDENT;
        end
        else if (c == "~")
        begin
            single(v, n, CLS_OPERATOR, c, st.line);
        end
        else if (is_op_start(c))
        begin
            st.held0 = c;
            st.held_count = 2'd1;
            st.mode = M_OP;
        end
        else if (is_punct(c))
        begin
            single(v, n, CLS_PUNCT, c, st.line);
        end
        else
        begin
            fail(st, v, n, ERR_UNEXPECTED, st.line);
        end
    endfunction

    function automatic void feed_core(inout lex_state_t st, inout res_vec_t v,
                                      inout logic [2:0] n, input logic [7:0] c);
        logic [7:0] h0;
        h0 = st.held0;
        case (st.mode)
            M_IDLE:
            begin
                idle_f(st, v, n, c);
            end
            M_HASH:
            begin
                if (c == "|")
                begin
                    st.block_line = st.line;
                    st.mode = M_BLOCK;
                end
                else if (c == 8'h0A)
                begin
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
                else
                begin
                    st.mode = M_LINECOM;
                end
            end
            M_LINECOM:
            begin
                if (c == 8'h0A)
                begin
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
            end
            M_BLOCK, M_BLOCKBAR:
            begin
                if (c == 8'h0A)
                begin
                    line_step(st);
                    st.mode = M_BLOCK;
                end
                else if (c == "|")
                begin
                    st.mode = M_BLOCKBAR;
                end
                else if (c == "#" && st.mode == M_BLOCKBAR)
                begin
                    go_idle(st);
                end
                else
                begin
                    st.mode = M_BLOCK;
                end
            end
            M_IDENT:
            begin
                if (is_word(c))
                begin
                    tok_add(st, v, n, CLS_IDENT, c);
                end
                else
                begin
                    tok_finish(st, v, n, CLS_IDENT);
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
            end
            M_AT:
            begin
                if (is_word(c))
                begin
                    tok_add(st, v, n, CLS_AT_NAME, c);
                end
                else if (st.pend_first)
                begin
                    fail(st, v, n, ERR_NO_NAME, st.line);
                end
                else
                begin
                    tok_finish(st, v, n, CLS_AT_NAME);
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
            end
            M_NUM:
            begin
                if (is_num_char(c) || c == ".")
                begin
                    tok_add(st, v, n, CLS_NUMBER, c);
                end
                else if (c == "e" || c == "E")
                begin
                    st.held0 = c;
                    st.held_count = 2'd1;
                    st.mode = M_NUMEXPSTART;
                end
                else
                begin
                    tok_finish(st, v, n, CLS_NUMBER);
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
            end
            M_NUMEXPSTART:
            begin
                if (is_num_char(c))
                begin
                    tok_add(st, v, n, CLS_NUMBER, st.held0);
                    if (st.held_count == 2'd2)
                    begin
                        tok_add(st, v, n, CLS_NUMBER, st.held1);
                    end
                    tok_add(st, v, n, CLS_NUMBER, c);
                    st.held_count = 2'd0;
                    st.mode = M_NUMEXP;
                end
                else if (st.held_count == 2'd1 && (c == "+" || c == "-"))
                begin
                    st.held1 = c;
                    st.held_count = 2'd2;
                end
            end
            M_NUMEXP:
            begin
                if (is_num_char(c))
                begin
                    tok_add(st, v, n, CLS_NUMBER, c);
                end
                else
                begin
                    tok_finish(st, v, n, CLS_NUMBER);
                    go_idle(st);
                    idle_f(st, v, n, c);
                end
            end
            M_DOT:
            begin
                go_idle(st);
                if (is_num_char(c))
                begin
                    tok_start(st, ".");
                    tok_add(st, v, n, CLS_NUMBER, c);
                    st.mode = M_NUM;
                end
                else
                begin
                    single(v, n, CLS_PUNCT, ".", st.line);
                    idle_f(st, v, n, c);
                end
            end
            M_STR:
            begin
                if (c == "\\")
                begin
                    st.mode = M_STRESC;
                end
                else if (c == "\"")
                begin
                    tok_finish(st, v, n, CLS_STRING);
                    go_idle(st);
                end
                else
                begin
                    if (c == 8'h0A)
                    begin
                        line_step(st);
                    end
                    tok_add(st, v, n, CLS_STRING, c);
                end
            end
            M_STRESC:
            begin
                st.mode = M_STR;
                if (c == "n")
                begin
                    tok_add(st, v, n, CLS_STRING, 8'h0A);
                end
                else if (c == "t")
                begin
                    tok_add(st, v, n, CLS_STRING, 8'h09);
                end
                else if (c == "r")
                begin
                    tok_add(st, v, n, CLS_STRING, 8'h0D);
                end
                else if (c == "\\" || c == "\"" || c == "'")
                begin
                    tok_add(st, v, n, CLS_STRING, c);
                end
                else
                begin
                    tok_add(st, v, n, CLS_STRING, "\\");
                    tok_add(st, v, n, CLS_STRING, c);
                end
            end
            M_CHR:
            begin
                if (st.held_count == 2'd0)
                begin
                    if (c == "\\")
                    begin
                        st.mode = M_CHRESC;
                    end
                    else
                    begin
                        st.held0 = c;
                        st.held_count = 2'd1;
                    end
                end
                else if (c == "'")
                begin
                    single(v, n, CLS_CHAR, st.held0, st.line);
                    go_idle(st);
                end
                else
                begin
                    fail(st, v, n, ERR_BAD_CHAR, st.line);
                end
            end
            M_CHRESC:
            begin
                if (c == "n")
                begin
                    st.held0 = 8'h0A;
                end
                else if (c == "t")
                begin
                    st.held0 = 8'h09;
                end
                else
                begin
                    st.held0 = c;
                end
                st.held_count = 2'd1;
                st.mode = M_CHR;
            end
            default:
            begin
                if (st.held_count == 2'd2)
                begin
                    go_idle(st);
                    push(v, n, mk(CLS_OPERATOR, h0, 1'b1, 1'b1, 1'b0, st.line, ERR_NONE));
                    if (c == "=")
                    begin
                        push(v, n, mk(CLS_OPERATOR, h0, 1'b1, 1'b0, 1'b0, st.line, ERR_NONE));
                        push(v, n, mk(CLS_OPERATOR, c, 1'b1, 1'b0, 1'b1, st.line, ERR_NONE));
                    end
                    else
                    begin
                        push(v, n, mk(CLS_OPERATOR, h0, 1'b1, 1'b0, 1'b1, st.line, ERR_NONE));
                        idle_f(st, v, n, c);
                    end
                end
                else if ((h0 == "<" || h0 == ">") && c == h0)
                begin
                    st.held_count = 2'd2;
                end
                else if (op_pair(h0, c))
                begin
                    go_idle(st);
                    push(v, n, mk(CLS_OPERATOR, h0, 1'b1, 1'b1, 1'b0, st.line, ERR_NONE));
                    push(v, n, mk(CLS_OPERATOR, c, 1'b1, 1'b0, 1'b1, st.line, ERR_NONE));
                end
                else
                begin
                    go_idle(st);
                    single(v, n, (h0 == ":") ? CLS_PUNCT : CLS_OPERATOR, h0, st.line);
                    idle_f(st, v, n, c);
                end
            end
        endcase
    endfunction

    function automatic void end_core(inout lex_state_t st, inout res_vec_t v,
                                     inout logic [2:0] n);
        case (st.mode)
            M_IDLE, M_HASH, M_LINECOM:
            begin
                eof_out(st, v, n);
            end
            M_BLOCK, M_BLOCKBAR:
            begin
                fail(st, v, n, ERR_OPEN_BLOCK, st.block_line);
            end
            M_IDENT:
            begin
                tok_finish(st, v, n, CLS_IDENT);
                eof_out(st, v, n);
            end
            M_NUM, M_NUMEXP:
            begin
                tok_finish(st, v, n, CLS_NUMBER);
                eof_out(st, v, n);
            end
            M_AT:
            begin
                if (st.pend_first)
                begin
                    fail(st, v, n, ERR_NO_NAME, st.line);
                end
                else
                begin
                    tok_finish(st, v, n, CLS_AT_NAME);
                    eof_out(st, v, n);
                end
            end
            M_DOT:
            begin
                single(v, n, CLS_PUNCT, ".", st.line);
                eof_out(st, v, n);
            end
            M_STR, M_STRESC:
            begin
                fail(st, v, n, ERR_OPEN_STR, st.line);
            end
            M_CHR, M_CHRESC:
            begin
                fail(st, v, n, ERR_BAD_CHAR, st.line);
            end
            M_OP:
            begin
                if (st.held_count == 2'd2)
                begin
                    push(v, n, mk(CLS_OPERATOR, st.held0, 1'b1, 1'b1, 1'b0, st.line, ERR_NONE));
                    push(v, n, mk(CLS_OPERATOR, st.held0, 1'b1, 1'b0, 1'b1, st.line, ERR_NONE));
                end
                else
                begin
                    single(v, n, (st.held0 == ":") ? CLS_PUNCT : CLS_OPERATOR, st.held0,
                           st.line);
                end
                eof_out(st, v, n);
            end
            default:
            begin
                st.stopped = 1'b1;
            end
        endcase
        st.stopped = 1'b1;
    endfunction

    // Drop a failed exponent: close the number and relex the held bytes.
    function automatic void exp_unwind(inout lex_state_t st, inout res_vec_t v,
                                       inout logic [2:0] n);
        logic [7:0] h0;
        logic [7:0] h1;
        logic       two;
        h0 = st.held0;
        h1 = st.held1;
        two = (st.held_count == 2'd2);
        tok_finish(st, v, n, CLS_NUMBER);
        go_idle(st);
        idle_f(st, v, n, h0);
        if (two)
        begin
            feed_core(st, v, n, h1);
        end
    endfunction

    function automatic void lex_step(input lex_state_t st_in, input logic kind,
                                     input logic [7:0] c, output lex_state_t st_out,
                                     output res_vec_t v, output logic [2:0] n);
        lex_state_t st;
        logic       unwind;
        st = st_in;
        v = '0;
        n = 3'd0;
        unwind = (st.mode == M_NUMEXPSTART) &&
                 (kind || !(is_num_char(c) ||
                            (st.held_count == 2'd1 && (c == "+" || c == "-"))));
        if (!st.stopped)
        begin
            if (unwind)
            begin
                exp_unwind(st, v, n);
            end
            if (kind)
            begin
                end_core(st, v, n);
            end
            else
            begin
                feed_core(st, v, n, c);
            end
        end
        st_out = st;
    endfunction

endpackage
`default_nettype wire

/* src/stl_lexer.sv */
`default_nettype none
module stl_lexer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            kind,
    input  logic [7:0]      byte_in,
    output stl_pkg::batch_t batch
);
    import stl_pkg::*;

    `include "script_source_tokenizer_defines.svh"

    lex_state_t state_reg;
    lex_state_t state_next;
    res_vec_t   res_c;
    logic [2:0] cnt_c;

    always_comb
    begin
        lex_step(state_reg, kind, byte_in, state_next, res_c, cnt_c);
    end

    assign batch.res = res_c;
    assign batch.cnt = cnt_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_state();
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    `STL_ASSERT_NEXT(a_stop_sticks, state_reg.stopped, state_reg.stopped)
    `STL_ASSERT_NOW(a_stopped_silent, state_reg.stopped, cnt_c == 3'd0)
    `STL_ASSERT_NOW(a_line_nonzero, 1'b1, state_reg.line != '0)

endmodule
`default_nettype wire

/* src/stl_outbuf.sv */
`default_nettype none
module stl_outbuf (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  stl_pkg::batch_t                 batch,
    output logic                            take_ok,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [3:0]                      token_class,
    output logic [7:0]                      text_char,
    output logic                            char_valid,
    output logic                            token_first,
    output logic                            token_final,
    output logic [stl_pkg::LINE_BITS-1:0]   line_number,
    output logic [2:0]                      error_code,
    output logic                            last
);
    import stl_pkg::*;

    `include "script_source_tokenizer_defines.svh"

    res_vec_t   res_reg;
    logic [2:0] rem_reg;
    logic [1:0] idx_reg;
    logic       out_fire;
    res_t       cur;

    assign out_valid = (rem_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;
    assign take_ok   = !out_valid || (out_fire && rem_reg == 3'd1);
    assign cur       = res_reg[idx_reg];

    assign token_class = cur.cls;
    assign text_char   = cur.ch;
    assign char_valid  = cur.ok;
    assign token_first = cur.first;
    assign token_final = cur.fin;
    assign line_number = cur.line;
    assign error_code  = cur.err;
    assign last        = (rem_reg == 3'd1);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            rem_reg <= batch.cnt;
            idx_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    `STL_ASSERT_NOW(a_rem_bound, 1'b1, rem_reg <= 3'(MAX_RES))
    `STL_ASSERT_NEXT(a_idx_step, out_fire && rem_reg > 3'd1, idx_reg == $past(idx_reg) + 2'd1)
    `STL_ASSERT_NOW(a_idx_fits, out_valid, {1'b0, idx_reg} + rem_reg <= 3'(MAX_RES))

endmodule
`default_nettype wire

/* src/script_source_tokenizer.sv */
// Streaming source tokenizer.
// Input channel (in_valid/in_ready): one beat per source byte (kind 0, byte_in)
// or the end-of-source beat (kind 1). Output channel (out_valid/out_ready): one
// beat per token character, eof or error result; last marks the final beat
// caused by one input beat. An input beat may cause zero to four output beats.
// An accepted beat is held in the input register and lexed from there; its
// results are loaded into the output buffer once it can take them, and are
// presented from that register. While out_ready is high: one input beat per
// cycle if each causes at most one result; a beat with several results holds
// the output buffer, its single port draining one result per cycle.
// When out_ready is low the result buffer holds, the input register fills,
// and in_ready drops until the buffer frees up.
// Reset (rst_n low, asynchronous) empties both registers, returns the lexer
// to idle at line one and clears the stop flag. After an eof or error result
// further input beats are accepted and give no results until reset.
`default_nettype none
module script_source_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [7:0]                    byte_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    token_class,
    output logic [7:0]                    text_char,
    output logic                          char_valid,
    output logic                          token_first,
    output logic                          token_final,
    output logic [stl_pkg::LINE_BITS-1:0] line_number,
    output logic [2:0]                    error_code,
    output logic                          last
);
    import stl_pkg::*;

    logic       in_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       take_ok;
    logic       fire;
    batch_t     batch;

    assign fire     = in_valid_reg && take_ok;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            byte_reg <= byte_in;
        end
    end

    stl_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .kind    (kind_reg),
        .byte_in (byte_reg),
        .batch   (batch)
    );

    stl_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .batch       (batch),
        .take_ok     (take_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_class (token_class),
        .text_char   (text_char),
        .char_valid  (char_valid),
        .token_first (token_first),
        .token_final (token_final),
        .line_number (line_number),
        .error_code  (error_code),
        .last        (last)
    );

endmodule
`default_nettype wire
